@@ design/scml_pkg.sv @@
// Shared types and constants for the sorted complex magnitude list.
package scml_pkg;

  localparam int unsigned CapacityDefault  = 32;
  localparam int unsigned PartWidthDefault = 16;
  localparam int unsigned COUNT_W          = 6;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned OP_W             = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

@@ design/scml_front.sv @@
// Front end: accepts input beats, decodes the operation and queues them.
module scml_front import scml_pkg::*; #(
  parameter int unsigned PART_WIDTH = PartWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [PART_WIDTH-1:0] real_part_i,
  input  logic [PART_WIDTH-1:0] imag_part_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output op_e                   q_op_o,
  output logic [PART_WIDTH-1:0] q_re_o,
  output logic [PART_WIDTH-1:0] q_im_o
);

  op_e                   op_mem [2];
  logic [PART_WIDTH-1:0] re_mem [2];
  logic [PART_WIDTH-1:0] im_mem [2];
  logic                  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]            fill_q, fill_d;
  logic                  push, pop;
  op_e                   op_dec;

  always_comb begin
    unique case (operation_i)
      2'd0:    op_dec = OP_INSERT;
      2'd1:    op_dec = OP_REMOVE;
      2'd2:    op_dec = OP_DUMP;
      default: op_dec = OP_NONE;
    endcase
  end

  assign in_ready_o = (fill_q != 2'd2);
  assign q_valid_o  = (fill_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;
  assign wptr_d     = push ? ~wptr_q : wptr_q;
  assign rptr_d     = pop ? ~rptr_q : rptr_q;
  assign fill_d     = fill_q + {1'b0, push} - {1'b0, pop};
  assign q_op_o     = op_mem[rptr_q];
  assign q_re_o     = re_mem[rptr_q];
  assign q_im_o     = im_mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_mem[wptr_q] <= op_dec;
      re_mem[wptr_q] <= real_part_i;
      im_mem[wptr_q] <= imag_part_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

endmodule

@@ design/scml_back.sv @@
// Back end: table memory and the sequencer that inserts, removes and dumps.
module scml_back import scml_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDefault,
  parameter int unsigned PART_WIDTH = PartWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  op_e                   q_op_i,
  input  logic [PART_WIDTH-1:0] q_re_i,
  input  logic [PART_WIDTH-1:0] q_im_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PART_WIDTH-1:0] out_real_o,
  output logic [PART_WIDTH-1:0] out_imag_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [COUNT_W-1:0]    removed_count_o,
  output logic [COUNT_W-1:0]    entry_count_o,
  output logic                  last_o
);

  localparam int unsigned PW = PART_WIDTH;
  localparam int unsigned MW = 2 * PW + 1;
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAG1  = 3'd1;
  localparam logic [2:0] ST_MAG2  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_EV    = 3'd4;
  localparam logic [2:0] ST_PLACE = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [PW-1:0] mem_re  [CAPACITY];
  logic [PW-1:0] mem_im  [CAPACITY];
  logic [MW-1:0] mem_mag [CAPACITY];
  logic [PW-1:0] rd_re_q, rd_im_q;
  logic [MW-1:0] rd_mag_q;

  logic          we;
  logic [IW-1:0] waddr;
  logic [PW-1:0] wre, wim;
  logic [MW-1:0] wmag;

  logic [2:0]          st_q, st_d;
  op_e                 op_q, op_d;
  logic [PW-1:0]       re_q, re_d, im_q, im_d;
  logic [2*PW-1:0]     sqr_q, sqr_d, sqi_q, sqi_d;
  logic [MW-1:0]       mag_q, mag_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       kept_q, kept_d, rem_q, rem_d, cnt_q, cnt_d;
  logic [STATUS_W-1:0] stat_q, stat_d;

  logic                ov_q, ov_d, olast_q, olast_d;
  logic [PW-1:0]       ore_q, ore_d, oim_q, oim_d;
  logic [STATUS_W-1:0] ost_q, ost_d;
  logic [COUNT_W-1:0]  orem_q, orem_d, ocnt_q, ocnt_d;

  logic          free;
  logic [PW-1:0] abs_re, abs_im;
  logic [CW-1:0] cnt_m1;

  assign free      = !ov_q || out_ready_i;
  assign abs_re    = re_q[PW-1] ? (~re_q + 1'b1) : re_q;
  assign abs_im    = im_q[PW-1] ? (~im_q + 1'b1) : im_q;
  assign cnt_m1    = cnt_q - 1'b1;
  assign q_ready_o = (st_q == ST_IDLE);

  always_comb begin
    logic [CW-1:0] kept_n, rem_n;
    kept_n = kept_q;
    rem_n  = rem_q;
    st_d   = st_q;
    op_d   = op_q;
    re_d   = re_q;
    im_d   = im_q;
    sqr_d  = sqr_q;
    sqi_d  = sqi_q;
    mag_d  = mag_q;
    idx_d  = idx_q;
    kept_d = kept_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    stat_d = stat_q;
    we     = 1'b0;
    waddr  = idx_q;
    wre    = re_q;
    wim    = im_q;
    wmag   = mag_q;
    ov_d    = ov_q && !out_ready_i;
    olast_d = olast_q;
    ore_d   = ore_q;
    oim_d   = oim_q;
    ost_d   = ost_q;
    orem_d  = orem_q;
    ocnt_d  = ocnt_q;

    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          op_d   = q_op_i;
          re_d   = q_re_i;
          im_d   = q_im_i;
          stat_d = STATUS_OK;
          rem_d  = '0;
          kept_d = '0;
          st_d   = ST_EMIT;
          unique case (q_op_i)
            OP_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) stat_d = STATUS_FULL;
              else st_d = ST_MAG1;
            end
            OP_REMOVE: begin
              idx_d = '0;
              if (cnt_q != '0) st_d = ST_RD;
            end
            OP_DUMP: begin
              idx_d = cnt_m1[IW-1:0];
              if (cnt_q == '0) stat_d = STATUS_EMPTY;
              else st_d = ST_RD;
            end
            default: st_d = ST_EMIT;
          endcase
        end
      end
      ST_MAG1: begin
        sqr_d = abs_re * abs_re;
        sqi_d = abs_im * abs_im;
        st_d  = ST_MAG2;
      end
      ST_MAG2: begin
        mag_d = MW'(sqr_q) + MW'(sqi_q);
        if (cnt_q == '0) begin
          we    = 1'b1;
          waddr = '0;
          wmag  = mag_d;
          cnt_d = cnt_q + 1'b1;
          st_d  = ST_EMIT;
        end else begin
          idx_d = cnt_m1[IW-1:0];
          st_d  = ST_RD;
        end
      end
      ST_RD: st_d = ST_EV;
      ST_EV: begin
        case (op_q)
          OP_INSERT: begin
            we    = 1'b1;
            waddr = idx_q + 1'b1;
            if (rd_mag_q > mag_q) begin
              wre  = rd_re_q;
              wim  = rd_im_q;
              wmag = rd_mag_q;
              if (idx_q == '0) begin
                st_d = ST_PLACE;
              end else begin
                idx_d = idx_q - 1'b1;
                st_d  = ST_RD;
              end
            end else begin
              cnt_d = cnt_q + 1'b1;
              st_d  = ST_EMIT;
            end
          end
          OP_REMOVE: begin
            if (rd_re_q == re_q && rd_im_q == im_q) begin
              rem_n = rem_q + 1'b1;
            end else begin
              we     = 1'b1;
              waddr  = kept_q[IW-1:0];
              wre    = rd_re_q;
              wim    = rd_im_q;
              wmag   = rd_mag_q;
              kept_n = kept_q + 1'b1;
            end
            kept_d = kept_n;
            rem_d  = rem_n;
            if (CW'(idx_q) == cnt_m1) begin
              cnt_d = kept_n;
              st_d  = ST_EMIT;
            end else begin
              idx_d = idx_q + 1'b1;
              st_d  = ST_RD;
            end
          end
          default: begin
            if (free) begin
              ov_d    = 1'b1;
              ore_d   = rd_re_q;
              oim_d   = rd_im_q;
              ost_d   = STATUS_OK;
              orem_d  = '0;
              ocnt_d  = COUNT_W'(cnt_q);
              olast_d = (idx_q == '0);
              if (idx_q == '0) begin
                st_d = ST_IDLE;
              end else begin
                idx_d = idx_q - 1'b1;
                st_d  = ST_RD;
              end
            end
          end
        endcase
      end
      ST_PLACE: begin
        we    = 1'b1;
        waddr = '0;
        cnt_d = cnt_q + 1'b1;
        st_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (free) begin
          ov_d    = 1'b1;
          ore_d   = '0;
          oim_d   = '0;
          ost_d   = stat_q;
          orem_d  = COUNT_W'(rem_q);
          ocnt_d  = COUNT_W'(cnt_q);
          olast_d = 1'b1;
          st_d    = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_re[waddr]  <= wre;
      mem_im[waddr]  <= wim;
      mem_mag[waddr] <= wmag;
    end
    rd_re_q  <= mem_re[idx_q];
    rd_im_q  <= mem_im[idx_q];
    rd_mag_q <= mem_mag[idx_q];
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    re_q    <= re_d;
    im_q    <= im_d;
    sqr_q   <= sqr_d;
    sqi_q   <= sqi_d;
    mag_q   <= mag_d;
    idx_q   <= idx_d;
    kept_q  <= kept_d;
    rem_q   <= rem_d;
    stat_q  <= stat_d;
    ore_q   <= ore_d;
    oim_q   <= oim_d;
    ost_q   <= ost_d;
    orem_q  <= orem_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign out_real_o      = ore_q;
  assign out_imag_o      = oim_q;
  assign status_o        = ost_q;
  assign removed_count_o = orem_q;
  assign entry_count_o   = ocnt_q;
  assign last_o          = olast_q;

endmodule

@@ design/sorted_complex_magnitude_list_unit.sv @@
// Top level of the sorted complex magnitude list.
//
// Keeps up to CAPACITY complex values sorted by ascending squared magnitude.
// Input channel (in_valid_i/in_ready_o): one beat carries an operation
// (insert, remove all equal, dump) and a real/imag pair.
// Output channel (out_valid_o/out_ready_i): insert, remove, unused codes and
// a dump of an empty table give one beat; any other dump gives one beat per
// entry, largest first, last_o on the final beat of each item.
// A two-entry queue sits between the front end and the sequencer, so input
// beats are taken while the sequencer is busy or the output is stalled.
// The sequencer walks its single-port table entry by entry: an insert reads
// down from the top and shifts each larger entry up one place, a remove
// compacts the table in one pass from the bottom, and a dump reads from the
// top entry down. Full, empty and unused items skip the walk. Reset empties
// the table.
// A stalled receiver holds the output register; the sequencer waits and the
// queue fills, then in_ready_o drops.
module sorted_complex_magnitude_list_unit import scml_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDefault,
  parameter int unsigned PART_WIDTH = PartWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [PART_WIDTH-1:0] real_part_i,
  input  logic [PART_WIDTH-1:0] imag_part_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PART_WIDTH-1:0] out_real_o,
  output logic [PART_WIDTH-1:0] out_imag_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [COUNT_W-1:0]    removed_count_o,
  output logic [COUNT_W-1:0]    entry_count_o,
  output logic                  last_o
);

  logic                  q_valid, q_ready;
  op_e                   q_op;
  logic [PART_WIDTH-1:0] q_re, q_im;

  scml_front #(.PART_WIDTH(PART_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .operation_i, .real_part_i, .imag_part_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_op_o(q_op),
    .q_re_o(q_re), .q_im_o(q_im)
  );

  scml_back #(.CAPACITY(CAPACITY), .PART_WIDTH(PART_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_op_i(q_op),
    .q_re_i(q_re), .q_im_i(q_im),
    .out_valid_o, .out_ready_i, .out_real_o, .out_imag_o, .status_o,
    .removed_count_o, .entry_count_o, .last_o
  );

endmodule

@@ design/scml_checker.sv @@
// Port-level checker for the sorted complex magnitude list, bound to the top.
module scml_checker import scml_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDefault,
  parameter int unsigned PART_WIDTH = PartWidthDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [PART_WIDTH-1:0] out_real_o,
  input logic [STATUS_W-1:0]   status_o,
  input logic [COUNT_W-1:0]    removed_count_o,
  input logic [COUNT_W-1:0]    entry_count_o,
  input logic                  last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_real_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_FULL |->
      entry_count_o == COUNT_W'(CAPACITY) && last_o)
    else $error("full status without a full table");

  a_empty_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EMPTY |-> entry_count_o == '0 && last_o)
    else $error("empty status with stored entries");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && removed_count_o != '0 |-> status_o == STATUS_OK && last_o)
    else $error("removal count on a non-remove beat");

endmodule

bind sorted_complex_magnitude_list_unit scml_checker #(
  .CAPACITY(CAPACITY), .PART_WIDTH(PART_WIDTH)
) u_scml_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_real_o, .status_o,
  .removed_count_o, .entry_count_o, .last_o
);

@@ tb/sv/tb_sorted_complex_magnitude_list_unit.sv @@
// Testbench for the sorted complex magnitude list: random and directed beats checked against a local model.
`timescale 1ns / 100ps

module tb_sorted_complex_magnitude_list_unit import scml_pkg::*;;

  localparam int unsigned CAP = 32;
  localparam int unsigned PW  = 16;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [PW-1:0]   re;
    logic [PW-1:0]   im;
  } cmd_t;

  typedef struct packed {
    logic [PW-1:0]       re;
    logic [PW-1:0]       im;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  removed;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } resp_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [OP_W-1:0] operation_i;
  logic [PW-1:0] real_part_i, imag_part_i, out_real_o, out_imag_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0] removed_count_o, entry_count_o;
  logic last_o;

  sorted_complex_magnitude_list_unit #(.CAPACITY(CAP), .PART_WIDTH(PW)) u_top (.*);

  cmd_t  pending_cmds[$];
  resp_t expected_beats[$];
  logic [PW-1:0] tbl_re[CAP];
  logic [PW-1:0] tbl_im[CAP];
  int unsigned tbl_n;
  int errors;
  int in_gap, out_gap;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic longint unsigned mag_sq(logic [PW-1:0] re, logic [PW-1:0] im);
    longint signed a, b;
    a = $signed(re);
    b = $signed(im);
    return a * a + b * b;
  endfunction

  function automatic resp_t mk(logic [PW-1:0] re, logic [PW-1:0] im,
                               logic [STATUS_W-1:0] st, int unsigned rm, bit lst);
    resp_t r;
    r.re = re; r.im = im; r.status = st;
    r.removed = rm[COUNT_W-1:0]; r.count = tbl_n[COUNT_W-1:0]; r.last = lst;
    return r;
  endfunction

  task automatic predict_list_op(cmd_t c);
    int unsigned pos, kept, rm;
    case (op_e'(c.op))
      OP_INSERT: begin
        if (tbl_n >= CAP) begin
          expected_beats.push_back(mk('0, '0, STATUS_FULL, 0, 1'b1));
        end else begin
          pos = tbl_n;
          for (int i = 0; i < tbl_n; i++)
            if (mag_sq(tbl_re[i], tbl_im[i]) > mag_sq(c.re, c.im)) begin
              pos = i;
              break;
            end
          for (int i = tbl_n; i > pos; i--) begin
            tbl_re[i] = tbl_re[i-1];
            tbl_im[i] = tbl_im[i-1];
          end
          tbl_re[pos] = c.re;
          tbl_im[pos] = c.im;
          tbl_n++;
          expected_beats.push_back(mk('0, '0, STATUS_OK, 0, 1'b1));
        end
      end
      OP_REMOVE: begin
        kept = 0; rm = 0;
        for (int i = 0; i < tbl_n; i++) begin
          if (tbl_re[i] == c.re && tbl_im[i] == c.im) rm++;
          else begin
            tbl_re[kept] = tbl_re[i];
            tbl_im[kept] = tbl_im[i];
            kept++;
          end
        end
        tbl_n = kept;
        expected_beats.push_back(mk('0, '0, STATUS_OK, rm, 1'b1));
      end
      OP_DUMP: begin
        if (tbl_n == 0) expected_beats.push_back(mk('0, '0, STATUS_EMPTY, 0, 1'b1));
        else for (int i = 0; i < tbl_n; i++)
          expected_beats.push_back(mk(tbl_re[tbl_n-1-i], tbl_im[tbl_n-1-i], STATUS_OK, 0,
                                      i + 1 == tbl_n));
      end
      default: expected_beats.push_back(mk('0, '0, STATUS_OK, 0, 1'b1));
    endcase
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic push(op_e op, logic [PW-1:0] re, logic [PW-1:0] im);
    cmd_t c;
    c.op = op; c.re = re; c.im = im;
    pending_cmds.push_back(c);
  endtask

  function automatic logic [PW-1:0] rand_part(bit narrow);
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return narrow ? PW'($signed($urandom_range(0, 6)) - 3) : PW'($urandom);
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= '0;
      real_part_i <= '0;
      imag_part_i <= '0;
      in_gap      = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        predict_list_op(cmd_t'({operation_i, real_part_i, imag_part_i}));
        in_gap = rand_gap();
      end
      if (in_gap > 0 || pending_cmds.size() == 0) begin
        in_valid_i <= 1'b0;
        if (in_gap > 0) in_gap--;
      end else begin
        cmd_t c;
        c = pending_cmds.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= c.op;
        real_part_i <= c.re;
        imag_part_i <= c.im;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected beat re=%h im=%h", out_real_o, out_imag_o);
          errors++;
        end else begin
          resp_t e;
          e = expected_beats.pop_front();
          if (out_real_o !== e.re) begin
            $error("out_real exp %h got %h", e.re, out_real_o); errors++;
          end
          if (out_imag_o !== e.im) begin
            $error("out_imag exp %h got %h", e.im, out_imag_o); errors++;
          end
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); errors++;
          end
          if (removed_count_o !== e.removed) begin
            $error("removed_count exp %0d got %0d", e.removed, removed_count_o); errors++;
          end
          if (entry_count_o !== e.count) begin
            $error("entry_count exp %0d got %0d", e.count, entry_count_o); errors++;
          end
          if (last_o !== e.last) begin
            $error("last exp %0d got %0d", e.last, last_o); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_gap <= rand_gap();
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned n;
    bit narrow;
    errors = 0;
    tbl_n = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    push(OP_DUMP, '0, '0);
    push(OP_REMOVE, 16'h0100, 16'h0100);
    push(OP_INSERT, 16'h8000, 16'h8000);
    push(OP_INSERT, 16'h7fff, 16'h7fff);
    push(OP_INSERT, 16'h0000, 16'h0000);
    push(OP_INSERT, 16'h0003, 16'hfffc);
    push(OP_INSERT, 16'hfffb, 16'h0000);
    push(OP_INSERT, 16'h0000, 16'h0005);
    push(OP_INSERT, 16'h0003, 16'hfffc);
    push(OP_NONE, 16'hffff, 16'hffff);
    push(OP_DUMP, '0, '0);
    push(OP_REMOVE, 16'h0003, 16'hfffc);
    push(OP_REMOVE, 16'h1234, 16'h4321);
    push(OP_DUMP, '0, '0);
    for (int i = 0; i < 28; i++) push(OP_INSERT, PW'($urandom), PW'($urandom));
    push(OP_INSERT, 16'h0001, 16'h0001);
    push(OP_DUMP, '0, '0);
    push(OP_REMOVE, 16'h8000, 16'h8000);
    push(OP_REMOVE, 16'h7fff, 16'h7fff);

    // random: bursts of mixed operations, each ended by a dump
    n = pending_cmds.size();
    while (n < 280) begin
      narrow = $urandom_range(0, 1);
      for (int k = 0, m = $urandom_range(4, 40); k < m; k++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) push(OP_INSERT, rand_part(narrow), rand_part(narrow));
        else if (r < 80) push(OP_REMOVE, rand_part(narrow), rand_part(narrow));
        else if (r < 95) push(OP_DUMP, PW'($urandom), PW'($urandom));
        else push(OP_NONE, PW'($urandom), PW'($urandom));
        n++;
      end
      push(OP_DUMP, '0, '0);
      n++;
    end

    wait (pending_cmds.size() == 0 && !in_valid_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_beats.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
